// ===== rtl/skbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skbb_pkg: shared types and constants of the skin tone bounding box
// fixed point color coefficients, register indexes, reset values
// ----------------------------------------------------------------------------
package skbb_pkg;

    localparam int PIX_W   = 8;
    localparam int BOX_W   = 12;
    localparam int DIM_W   = 13;
    localparam int CFG_W   = 13;
    localparam int INDEX_W = 3;

    // q16 accumulator, wide enough for every sum of the conversion
    localparam int ACC_W = 26;

    localparam logic signed [ACC_W-1:0] CB_R   = -26'sd11059;
    localparam logic signed [ACC_W-1:0] CB_G   = -26'sd21712;
    localparam logic signed [ACC_W-1:0] CB_B   = 26'sd32768;
    localparam logic signed [ACC_W-1:0] CR_R   = 26'sd32768;
    localparam logic signed [ACC_W-1:0] CR_G   = -26'sd27440;
    localparam logic signed [ACC_W-1:0] CR_B   = -26'sd5328;
    localparam logic signed [ACC_W-1:0] OFFSET = 26'sd8388608;

    typedef enum logic [INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CB_LOW       = 3'd2,
        REG_CB_HIGH      = 3'd3,
        REG_CR_LOW       = 3'd4,
        REG_CR_HIGH      = 3'd5
    } reg_index_t;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [PIX_W-1:0] RST_CB_LOW       = 8'd95;
    localparam logic [PIX_W-1:0] RST_CB_HIGH      = 8'd120;
    localparam logic [PIX_W-1:0] RST_CR_LOW       = 8'd140;
    localparam logic [PIX_W-1:0] RST_CR_HIGH      = 8'd185;

    typedef struct packed {
        logic [PIX_W-1:0] cb_low;
        logic [PIX_W-1:0] cb_high;
        logic [PIX_W-1:0] cr_low;
        logic [PIX_W-1:0] cr_high;
    } window_t;

endpackage
`default_nettype wire

// ===== rtl/skbb_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skbb_ifs: stream channels of the skin tone bounding box
// pixel channel in, masked pixel plus box channel out
// ----------------------------------------------------------------------------
interface skbb_pixel_if;
    import skbb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pix_blue;
    logic [PIX_W-1:0] pix_green;
    logic [PIX_W-1:0] pix_red;

    modport source (output valid, output pix_blue, output pix_green, output pix_red,
                    input ready);
    modport sink   (input valid, input pix_blue, input pix_green, input pix_red,
                    output ready);
endinterface

interface skbb_result_if;
    import skbb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mask_blue;
    logic [PIX_W-1:0] mask_green;
    logic [PIX_W-1:0] mask_red;
    logic             is_skin;
    logic             frame_done;
    logic             box_found;
    logic [BOX_W-1:0] box_left;
    logic [BOX_W-1:0] box_top;
    logic [BOX_W-1:0] box_right;
    logic [BOX_W-1:0] box_bottom;

    modport source (output valid, output mask_blue, output mask_green, output mask_red,
                    output is_skin, output frame_done, output box_found,
                    output box_left, output box_top, output box_right, output box_bottom,
                    input ready);
    modport sink   (input valid, input mask_blue, input mask_green, input mask_red,
                    input is_skin, input frame_done, input box_found,
                    input box_left, input box_top, input box_right, input box_bottom,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/skbb_skin_detect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skbb_skin_detect: chroma conversion and window test
// q16 cb/cr from bgr, floor and clamp to a byte, strict window compare
// ----------------------------------------------------------------------------
module skbb_skin_detect (
    input  wire logic [skbb_pkg::PIX_W-1:0] blue,
    input  wire logic [skbb_pkg::PIX_W-1:0] green,
    input  wire logic [skbb_pkg::PIX_W-1:0] red,
    input  wire skbb_pkg::window_t          window,
    output logic                            is_skin
);
    import skbb_pkg::*;

    logic signed [ACC_W-1:0] b_s, g_s, r_s;
    logic signed [ACC_W-1:0] cb_acc, cr_acc;
    logic [PIX_W-1:0]        cb, cr;

    // floor of q16 value, clamped to 0..255
    function automatic logic [PIX_W-1:0] to_byte(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-17:0] whole;
        begin
            whole = acc[ACC_W-1:16];
            if (acc[ACC_W-1])
                to_byte = '0;
            else if (whole > (ACC_W-16)'(255))
                to_byte = '1;
            else
                to_byte = whole[PIX_W-1:0];
        end
    endfunction

    assign b_s = $signed({{(ACC_W-PIX_W){1'b0}}, blue});
    assign g_s = $signed({{(ACC_W-PIX_W){1'b0}}, green});
    assign r_s = $signed({{(ACC_W-PIX_W){1'b0}}, red});

    assign cb_acc = CB_R * r_s + CB_G * g_s + CB_B * b_s + OFFSET;
    assign cr_acc = CR_R * r_s + CR_G * g_s + CR_B * b_s + OFFSET;

    assign cb = to_byte(cb_acc);
    assign cr = to_byte(cr_acc);

    assign is_skin = (cb > window.cb_low) && (cb < window.cb_high) &&
                     (cr > window.cr_low) && (cr < window.cr_high);

endmodule
`default_nettype wire

// ===== rtl/skin_tone_bounding_box.sv =====
`timescale 1ns / 1ps
`default_nettype none
// each pixel passes the input register and then the result register on its way out
// throughput: 1 pixel per cycle unless stalled, set by the single compute stage between
// the two registers; a stalled result holds while the input register takes one more pixel
// reset: async active low; counters and box cleared, config back to 640x480 and the
// default cb/cr windows, both pipeline stages empty
// ----------------------------------------------------------------------------
// skin_tone_bounding_box: ycbcr skin mask with per-frame bounding box
// masks each raster-order pixel and reports the skin box on the frame's last pixel
// ----------------------------------------------------------------------------
module skin_tone_bounding_box #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [skbb_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [skbb_pkg::CFG_W-1:0]  cfg_data,
    skbb_pixel_if.sink                       pixel,
    skbb_result_if.source                    result
);
    import skbb_pkg::*;

    // counter width covers every column/row index below MAX_DIM
    localparam int CW = $clog2(MAX_DIM);
    // compare width holds both a 13-bit size and MAX_DIM itself
    localparam int MW = $clog2(MAX_DIM + 1);
    localparam int LW = (MW > DIM_W) ? MW : DIM_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_DIM);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    window_t          window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            window_reg.cb_low  <= RST_CB_LOW;
            window_reg.cb_high <= RST_CB_HIGH;
            window_reg.cr_low  <= RST_CR_LOW;
            window_reg.cr_high <= RST_CR_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg    <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg   <= cfg_data;
                REG_CB_LOW:       window_reg.cb_low  <= cfg_data[PIX_W-1:0];
                REG_CB_HIGH:      window_reg.cb_high <= cfg_data[PIX_W-1:0];
                REG_CR_LOW:       window_reg.cr_low  <= cfg_data[PIX_W-1:0];
                REG_CR_HIGH:      window_reg.cr_high <= cfg_data[PIX_W-1:0];
                default:          ; // unknown index, write dropped
            endcase
        end
    end

    // last index of a dimension: size 0 acts as 1, sizes above MAX_DIM saturate
    function automatic logic [LW-1:0] last_index(input logic [DIM_W-1:0] size);
        logic [LW-1:0] s;
        begin
            s = LW'(size);
            if (s == '0)
                last_index = '0;
            else if (s > MAX_L)
                last_index = MAX_L - LW'(1);
            else
                last_index = s - LW'(1);
        end
    endfunction

    // box coordinates leave as 12 bits whatever the counter width
    function automatic logic [BOX_W-1:0] to_box(input logic [CW-1:0] v);
        logic [BOX_W+CW-1:0] ext;
        begin
            ext    = {{BOX_W{1'b0}}, v};
            to_box = ext[BOX_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // handshake: the result register parts the two sides
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic res_valid_reg;
    logic advance;

    assign advance     = !res_valid_reg || result.ready;
    assign pixel.ready = !s1_valid_reg || advance;

    // input register
    logic [PIX_W-1:0] s1_blue_reg, s1_green_reg, s1_red_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pixel.ready)
            s1_valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            s1_blue_reg  <= pixel.pix_blue;
            s1_green_reg <= pixel.pix_green;
            s1_red_reg   <= pixel.pix_red;
        end
    end

    // ------------------------------------------------------------------
    // compute stage: skin test, raster position, box tracking
    // ------------------------------------------------------------------
    logic skin;

    skbb_skin_detect u_detect (
        .blue    (s1_blue_reg),
        .green   (s1_green_reg),
        .red     (s1_red_reg),
        .window  (window_reg),
        .is_skin (skin)
    );

    logic [CW-1:0] column_reg, row_reg;
    logic [CW-1:0] min_col_reg, min_row_reg, max_col_reg, max_row_reg;
    logic          any_found_reg;

    logic [CW-1:0] min_col_next, min_row_next, max_col_next, max_row_next;
    logic          any_found_next;
    logic          last_col, last_row, done;
    logic          first_hit;

    // a counter past a shrunken size still counts as on the last column/row
    assign last_col = LW'(column_reg) >= last_index(frame_width_reg);
    assign last_row = LW'(row_reg) >= last_index(frame_height_reg);
    assign done     = last_col && last_row;

    assign first_hit = skin && !any_found_reg;

    // box including the current pixel
    always_comb
    begin
        min_col_next   = min_col_reg;
        min_row_next   = min_row_reg;
        max_col_next   = max_col_reg;
        max_row_next   = max_row_reg;
        any_found_next = any_found_reg || skin;
        if (first_hit)
        begin
            min_col_next = column_reg;
            max_col_next = column_reg;
            min_row_next = row_reg;
            max_row_next = row_reg;
        end
        else if (skin)
        begin
            if (column_reg < min_col_reg) min_col_next = column_reg;
            if (column_reg > max_col_reg) max_col_next = column_reg;
            if (row_reg < min_row_reg)    min_row_next = row_reg;
            if (row_reg > max_row_reg)    max_row_next = row_reg;
        end
    end

    logic step;
    assign step = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            min_col_reg   <= '1;
            min_row_reg   <= '1;
            max_col_reg   <= '0;
            max_row_reg   <= '0;
            any_found_reg <= 1'b0;
        end
        else if (step)
        begin
            if (done)
            begin
                // frame end: rewind and clear the box
                column_reg    <= '0;
                row_reg       <= '0;
                min_col_reg   <= '1;
                min_row_reg   <= '1;
                max_col_reg   <= '0;
                max_row_reg   <= '0;
                any_found_reg <= 1'b0;
            end
            else
            begin
                if (last_col)
                begin
                    column_reg <= '0;
                    row_reg    <= row_reg + CW'(1);
                end
                else
                begin
                    column_reg <= column_reg + CW'(1);
                end
                min_col_reg   <= min_col_next;
                min_row_reg   <= min_row_next;
                max_col_reg   <= max_col_next;
                max_row_reg   <= max_row_next;
                any_found_reg <= any_found_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic             report;
    logic [PIX_W-1:0] mask_blue_reg, mask_green_reg, mask_red_reg;
    logic             is_skin_reg, frame_done_reg, box_found_reg;
    logic [BOX_W-1:0] box_left_reg, box_top_reg, box_right_reg, box_bottom_reg;

    assign report = done && any_found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mask_blue_reg  <= skin ? s1_blue_reg  : '0;
            mask_green_reg <= skin ? s1_green_reg : '0;
            mask_red_reg   <= skin ? s1_red_reg   : '0;
            is_skin_reg    <= skin;
            frame_done_reg <= done;
            box_found_reg  <= report;
            box_left_reg   <= report ? to_box(min_col_next) : '0;
            box_top_reg    <= report ? to_box(min_row_next) : '0;
            box_right_reg  <= report ? to_box(max_col_next) : '0;
            box_bottom_reg <= report ? to_box(max_row_next) : '0;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.mask_blue  = mask_blue_reg;
    assign result.mask_green = mask_green_reg;
    assign result.mask_red   = mask_red_reg;
    assign result.is_skin    = is_skin_reg;
    assign result.frame_done = frame_done_reg;
    assign result.box_found  = box_found_reg;
    assign result.box_left   = box_left_reg;
    assign result.box_top    = box_top_reg;
    assign result.box_right  = box_right_reg;
    assign result.box_bottom = box_bottom_reg;

endmodule
`default_nettype wire
